>>> design/lmb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmb_pkg: shared types and constants of the level meter ballistics
// level format, register indexes and the constants of the pixel mapping
// ----------------------------------------------------------------------------
package lmb_pkg;

  typedef logic signed [15:0] level_t;
  typedef logic signed [16:0] level_ext_t;
  typedef logic [7:0]         px_t;

  // bar length in pixels
  localparam int unsigned BAR_PIXELS = 200;

  // -60 dB floor in 1/256 dB, and the span from floor to full scale
  localparam int          FLOOR_LEVEL = -15360;
  localparam int unsigned SPAN_LEVEL  = 15360;
  localparam int unsigned SPAN_W      = $clog2(SPAN_LEVEL);

  // register indexes on the configuration port
  localparam logic [1:0] REG_RELEASE_STEP   = 2'd0;
  localparam logic [1:0] REG_HOLD_TICKS     = 2'd1;
  localparam logic [1:0] REG_CLIP_THRESHOLD = 2'd2;

  // register reset values
  localparam logic [9:0] RELEASE_STEP_RST   = 10'd53;
  localparam logic [7:0] HOLD_TICKS_RST     = 8'd85;
  localparam level_t     CLIP_THRESHOLD_RST = -16'sd26;

  // px = floor((BAR_PIXELS*d + SPAN/2) / SPAN) as one multiply by a
  // rounded-up reciprocal; exact for d < SPAN and BAR_PIXELS < 256
  localparam int unsigned      FRAC_BITS = 36;
  localparam int unsigned      PROD_W    = 46;
  localparam longint unsigned  RECIP     =
    ((64'd1 << FRAC_BITS) + SPAN_LEVEL - 1) / SPAN_LEVEL;
  localparam logic [PROD_W-1:0] MAP_MUL = PROD_W'(BAR_PIXELS * RECIP);
  localparam logic [PROD_W-1:0] MAP_ADD = PROD_W'((SPAN_LEVEL / 2) * RECIP);

  // previous-pixel value meaning no tick yet
  localparam logic [8:0] PX_NONE = 9'd511;

  // marker shown when beyond this many pixels
  localparam px_t PEAK_MIN_PX = 8'd2;

  // item between the state update and the pixel mapping
  typedef struct packed {
    logic   is_tick;
    level_t shown;
    level_t peak;
    logic   clip;
  } lmb_stage_t;

endpackage

>>> design/level_meter_ballistics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// level_meter_ballistics: bar and peak-hold meter ballistics
// updates bar, peak marker and clip latch per item and maps them to pixels
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready): kind 0 is a tick carrying level_db in
//   signed 1/256 dBFS, kind 1 clears the clip latch
//   output channel (out_valid/out_ready): one result item per input item,
//   with bar and peak lengths in pixels, peak visibility, clip flag and a
//   flag telling whether the pixel values moved since the last tick
//   configuration: cfg_wr_en writes cfg_data into register cfg_index
//   (0 release step, 1 hold ticks, 2 clip threshold), index 3 is ignored
// timing
//   one item per cycle sustained while out_ready is high; an accepted item
//   goes through the ballistics update before the stage register and the
//   reciprocal multiply of the pixel mapping before the result register
// reset
//   synchronous rst empties both stages, puts bar and peak at the -60 dB
//   floor, clears hold and clip, and loads the register reset values
// stall
//   when out_ready is low the result holds; the stage register still takes
//   one more item, after which in_ready drops until the result is taken
// ----------------------------------------------------------------------------
module level_meter_ballistics
  import lmb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  level_t      level_db,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output px_t         bar_px,
  output px_t         peak_px,
  output logic        peak_visible,
  output logic        clip_flag,
  output logic        px_changed,
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  logic [9:0] release_step;
  logic [7:0] hold_ticks;
  level_t     clip_threshold;

  // ballistics state
  level_t     shown_level;
  level_t     peak_level;
  logic [7:0] hold_left;
  logic       clip_latched;
  logic [8:0] prev_bar_px;
  logic [8:0] prev_peak_px;

  // pipeline
  lmb_stage_t stage;
  logic       stage_valid;
  logic       in_acc;
  logic       advance;

  // next values of the ballistics
  level_ext_t lv_ext;
  level_ext_t shown_ext;
  level_ext_t peak_ext;
  level_ext_t shown_dec;
  level_ext_t shown_cand;
  level_ext_t peak_cand;
  level_t     shown_level_next;
  level_t     peak_level_next;
  logic [7:0] hold_left_next;
  logic       clip_latched_next;

  // pixel mapping of the staged item
  px_t        bar_map;
  px_t        peak_map;

  localparam level_ext_t FLOOR_EXT = 17'(FLOOR_LEVEL);

  assign in_acc   = in_valid && in_ready;
  assign advance  = !out_valid || out_ready;
  assign in_ready = !stage_valid || advance;

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      release_step   <= RELEASE_STEP_RST;
      hold_ticks     <= HOLD_TICKS_RST;
      clip_threshold <= CLIP_THRESHOLD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_RELEASE_STEP:   release_step   <= cfg_data[9:0];
        REG_HOLD_TICKS:     hold_ticks     <= cfg_data[7:0];
        REG_CLIP_THRESHOLD: clip_threshold <= level_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // ballistics update, all 17 bit signed so the release never wraps
  always_comb begin
    lv_ext    = 17'(level_db);
    shown_ext = 17'(shown_level);
    peak_ext  = 17'(peak_level);
    shown_dec = shown_ext - level_ext_t'({7'd0, release_step});

    // bar: instant attack, linear release clamped at the floor
    if (lv_ext > shown_ext) begin
      shown_cand = lv_ext;
    end else if (shown_dec < FLOOR_EXT) begin
      shown_cand = FLOOR_EXT;
    end else begin
      shown_cand = shown_dec;
    end

    // peak: catch, hold, then release
    hold_left_next = hold_left;
    if (lv_ext >= peak_ext) begin
      peak_cand      = lv_ext;
      hold_left_next = hold_ticks;
    end else if (hold_left != 8'd0) begin
      peak_cand      = peak_ext;
      hold_left_next = hold_left - 8'd1;
    end else begin
      peak_cand = peak_ext - level_ext_t'({7'd0, release_step});
    end

    // marker never sits below the bar
    if (peak_cand < shown_cand) begin
      peak_cand = shown_cand;
    end

    // both candidates are within the 16 bit range here
    if (kind) begin
      shown_level_next  = shown_level;
      peak_level_next   = peak_level;
      hold_left_next    = hold_left;
      clip_latched_next = 1'b0;
    end else begin
      shown_level_next  = shown_cand[15:0];
      peak_level_next   = peak_cand[15:0];
      clip_latched_next = clip_latched || (level_db >= clip_threshold);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shown_level  <= level_t'(FLOOR_LEVEL);
      peak_level   <= level_t'(FLOOR_LEVEL);
      hold_left    <= 8'd0;
      clip_latched <= 1'b0;
    end else if (in_acc) begin
      shown_level  <= shown_level_next;
      peak_level   <= peak_level_next;
      hold_left    <= hold_left_next;
      clip_latched <= clip_latched_next;
    end
  end

  // stage register: state snapshot after each item
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_acc) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stage.is_tick <= !kind;
      stage.shown   <= shown_level_next;
      stage.peak    <= peak_level_next;
      stage.clip    <= clip_latched_next;
    end
  end

  // level to pixels, rounded half up
  function automatic px_t level_to_px(input level_t lv);
    level_ext_t         d_ext;
    logic [SPAN_W-1:0]  d;
    logic [PROD_W-1:0]  prod;
    px_t                px;
    d_ext = 17'(lv) - FLOOR_EXT;
    d     = d_ext[SPAN_W-1:0];
    prod  = PROD_W'(d) * MAP_MUL + MAP_ADD;
    if (17'(lv) <= FLOOR_EXT) begin
      px = 8'd0;
    end else if (lv >= 16'sd0) begin
      px = px_t'(BAR_PIXELS);
    end else begin
      px = prod[FRAC_BITS +: 8];
    end
    return px;
  endfunction

  assign bar_map  = level_to_px(stage.shown);
  assign peak_map = level_to_px(stage.peak);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      bar_px       <= bar_map;
      peak_px      <= peak_map;
      peak_visible <= (peak_map > PEAK_MIN_PX);
      clip_flag    <= stage.clip;
      // clear items never report a change
      px_changed   <= stage.is_tick &&
                      (({1'b0, bar_map} != prev_bar_px) ||
                       ({1'b0, peak_map} != prev_peak_px));
    end
  end

  // last tick's pixels, only ticks move them
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_bar_px  <= PX_NONE;
      prev_peak_px <= PX_NONE;
    end else if (advance && stage_valid && stage.is_tick) begin
      prev_bar_px  <= {1'b0, bar_map};
      prev_peak_px <= {1'b0, peak_map};
    end
  end

endmodule

>>> design/lmb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmb_checker: port-level checks of the level meter ballistics
// empty result after reset, result ranges, marker ordering and result hold under stall
// ----------------------------------------------------------------------------
module lmb_checker
  import lmb_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input px_t         bar_px,
  input px_t         peak_px,
  input logic        peak_visible,
  input logic        clip_flag,
  input logic        px_changed
);

  // nothing comes out the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present right after reset");

  // stalled result keeps its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bar_px) && $stable(peak_px)
      && $stable(clip_flag) && $stable(px_changed))
    else $error("result changed while stalled");

  // pixel lengths stay on the bar
  a_px_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bar_px <= px_t'(BAR_PIXELS)) && (peak_px <= px_t'(BAR_PIXELS)))
    else $error("pixel length beyond bar");

  // marker never below the bar, visibility follows the marker
  a_peak_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (peak_px >= bar_px) && (peak_visible == (peak_px > PEAK_MIN_PX)))
    else $error("peak marker inconsistent with bar");

endmodule

bind level_meter_ballistics lmb_checker u_lmb_checker (.*);
